// ===== rtl/core/mc3_pkg.sv =====
// Package for the masked 3x3 RGB convolution core.
// Holds field widths, register codes, reset values and the word structs.
// No dependencies; every other file of the core imports it.
`default_nettype none

package mc3_pkg;

    localparam int CHAN_W     = 16;
    localparam int MASK_W     = 8;
    localparam int COL_W      = 12;
    localparam int ROW_W      = 14;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int KREG_W     = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int THR_W      = 9;
    localparam int WIDTH_W    = 13;
    localparam int HEIGHT_W   = 15;
    localparam int TAPS       = 9;
    localparam int CHANS      = 3;

    // Line buffer entry: mask and RGB of the line above, RGB of the line two above.
    localparam int LB_W = MASK_W + 2 * RGB_W;

    // Products, column sums and the full kernel sum.
    localparam int PROD_W = CHAN_W + 1 + CHAN_W;
    localparam int PSUM_W = PROD_W + 2;
    localparam int TSUM_W = PSUM_W + 2;

    localparam int MIN_DIM   = 3;
    localparam int CLAMP_MAX = 65535;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd480;
    localparam logic [KREG_W-1:0]   KMID_RESET   = 48'h0000_1000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_KERNEL_LEFT    = 3'd2,
        REG_KERNEL_MID     = 3'd3,
        REG_KERNEL_RIGHT   = 3'd4,
        REG_MASK_ENABLE    = 3'd5,
        REG_MASK_THRESHOLD = 3'd6
    } cfg_reg_t;

    typedef logic [RGB_W-1:0] rgb_t;

    // Side information that travels with a pixel through the arithmetic.
    typedef struct packed {
        rgb_t             pix;
        rgb_t             pass;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             interior;
        logic             border;
        logic             masked;
    } meta_t;

    typedef struct packed {
        rgb_t             rgb;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mc3_if.sv =====
// Stream interfaces of the masked 3x3 RGB convolution core.
// Depends on mc3_pkg for the field widths.
`default_nettype none

interface mc3_pixel_if import mc3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic [MASK_W-1:0] in_mask;

    modport source (output valid, in_red, in_green, in_blue, in_mask, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_mask, output ready);
endinterface

interface mc3_result_if import mc3_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic              out_last;

    modport source (output valid, out_red, out_green, out_blue, out_col, out_row, out_last,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row, out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mc3_linebuf.sv =====
// Two-line buffer memory: one write and one registered read per cycle.
// Depends on mc3_pkg for the entry width.
`default_nettype none

module mc3_linebuf
    import mc3_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
)
(
    input  wire logic            clk,
    input  wire logic            rd_en,
    input  wire logic [AW-1:0]   rd_addr,
    output logic      [LB_W-1:0] rd_data,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire logic [LB_W-1:0] wr_data
);

    logic [LB_W-1:0] mem [DEPTH];
    logic [LB_W-1:0] rd_data_reg;

    // Synchronous write and read; the read word holds until the next read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mc3_conv.sv =====
// Kernel arithmetic: products, column sums, total with truncation and clamp.
// Depends on mc3_pkg; three register stages that move together on adv.
`default_nettype none

module mc3_conv
    import mc3_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 12
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   adv,
    input  wire logic   in_valid,
    input  wire rgb_t   taps [TAPS],
    input  wire logic [KREG_W-1:0] kern [3],
    input  wire meta_t  in_meta,
    output logic        out_valid,
    output rgb_t        out_rgb,
    output meta_t       out_meta
);

    logic               p_valid_reg;
    meta_t              p_meta_reg;
    logic signed [PROD_W-1:0] prod_reg [CHANS][TAPS];

    logic               s_valid_reg;
    meta_t              s_meta_reg;
    logic signed [PSUM_W-1:0] psum_reg [CHANS][3];

    logic               t_valid_reg;
    meta_t              t_meta_reg;
    rgb_t               t_rgb_reg;
    rgb_t               t_rgb_next;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= in_valid;
            s_valid_reg <= p_valid_reg;
            t_valid_reg <= s_valid_reg;
        end
    end

    // Stage one: one product per channel and tap, sample times signed coefficient.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_meta_reg <= in_meta;
            for (int ch = 0; ch < CHANS; ch++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    prod_reg[ch][t] <=
                        $signed({1'b0, taps[t][CHAN_W*ch +: CHAN_W]}) *
                        $signed(kern[t/3][CHAN_W*(t%3) +: CHAN_W]);
                end
            end
        end
    end

    // Stage two: sum each kernel column.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_meta_reg <= p_meta_reg;
            for (int ch = 0; ch < CHANS; ch++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    psum_reg[ch][k] <= PSUM_W'(prod_reg[ch][3*k])
                                     + PSUM_W'(prod_reg[ch][3*k+1])
                                     + PSUM_W'(prod_reg[ch][3*k+2]);
                end
            end
        end
    end

    // Stage three: total, drop the fraction of a positive sum, clamp to the sample range.
    always_comb
    begin
        logic signed [TSUM_W-1:0] total;
        logic        [TSUM_W-1:0] q;
        t_rgb_next = '0;
        for (int ch = 0; ch < CHANS; ch++)
        begin
            total = TSUM_W'(psum_reg[ch][0]) + TSUM_W'(psum_reg[ch][1])
                  + TSUM_W'(psum_reg[ch][2]);
            q = TSUM_W'($unsigned(total) >> COEF_FRAC_BITS);
            if (total <= 0)
            begin
                t_rgb_next[CHAN_W*ch +: CHAN_W] = '0;
            end
            else if (q > TSUM_W'(CLAMP_MAX))
            begin
                t_rgb_next[CHAN_W*ch +: CHAN_W] = CHAN_W'(CLAMP_MAX);
            end
            else
            begin
                t_rgb_next[CHAN_W*ch +: CHAN_W] = q[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_meta_reg <= s_meta_reg;
            t_rgb_reg  <= t_rgb_next;
        end
    end

    assign out_valid = t_valid_reg;
    assign out_rgb   = t_rgb_reg;
    assign out_meta  = t_meta_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mc3_outbuf.sv =====
// Two-entry result buffer: takes a pixel's words at once, sends one a ready cycle.
// Depends on mc3_pkg and the result interface.
`default_nettype none

module mc3_outbuf
    import mc3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  load,
    input  wire rgb_t  conv_rgb,
    input  wire meta_t meta,
    output logic       can_load,
    mc3_result_if.source result
);

    result_t     e0_reg, e0_next;
    result_t     e1_reg, e1_next;
    logic [1:0]  cnt_reg, cnt_next;
    result_t     r_int, r_bor;
    logic        take;

    assign take     = result.valid && result.ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && take);

    // Candidate words: the interior pixel one step back, and the arriving pixel itself.
    always_comb
    begin
        r_int.rgb  = meta.masked ? meta.pass : conv_rgb;
        r_int.col  = meta.col - COL_W'(1);
        r_int.row  = meta.row - ROW_W'(1);
        r_int.last = !meta.border;
        r_bor.rgb  = meta.pix;
        r_bor.col  = meta.col;
        r_bor.row  = meta.row;
        r_bor.last = 1'b1;
    end

    // Load, shift and count.
    always_comb
    begin
        e0_next  = e0_reg;
        e1_next  = e1_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            e0_next  = meta.interior ? r_int : r_bor;
            e1_next  = r_bor;
            cnt_next = 2'(meta.interior) + 2'(meta.border);
        end
        else if (take)
        begin
            e0_next  = e1_reg;
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign result.valid     = (cnt_reg != 2'd0);
    assign result.out_red   = e0_reg.rgb[CHAN_W-1:0];
    assign result.out_green = e0_reg.rgb[2*CHAN_W-1:CHAN_W];
    assign result.out_blue  = e0_reg.rgb[3*CHAN_W-1:2*CHAN_W];
    assign result.out_col   = e0_reg.col;
    assign result.out_row   = e0_reg.row;
    assign result.out_last  = e0_reg.last;

endmodule

`default_nettype wire

// ===== rtl/core/masked_conv3x3_rgb16_core.sv =====
// Channel  | Dir | Payload                                   | Handshake
// pixel    | in  | in_red, in_green, in_blue, in_mask        | valid / ready
// result   | out | out_red/green/blue, out_col/row, out_last | valid / ready
// cfg      | in  | cfg_addr, cfg_wdata                       | cfg_we, no wait
//
// A pixel that yields at most one word is taken every cycle while results are
// taken; one that yields two words (interior result plus border pixel) holds
// the input until its second word is sent by the single-port result buffer.
// Words pass the first stage, the product, column-sum and total stages and the
// result buffer in that order. The line buffers need no clearing after reset.
// A result stall freezes the whole pipeline while the total stage holds a word.
// Top level of the masked 3x3 convolution; depends on mc3_pkg, the interfaces,
// mc3_linebuf, mc3_conv and mc3_outbuf.
`default_nettype none

module masked_conv3x3_rgb16_core
    import mc3_pkg::*;
#(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 16384,
    parameter int COEF_FRAC_BITS = 12
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    mc3_pixel_if.sink                  pixel,
    mc3_result_if.source               result
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WEW = $clog2(MAX_WIDTH + 1);
    localparam int HEW = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [KREG_W-1:0]   kern_reg [3];
    logic                men_reg;
    logic [THR_W-1:0]    thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            kern_reg[0] <= '0;
            kern_reg[1] <= KMID_RESET;
            kern_reg[2] <= '0;
            men_reg     <= 1'b0;
            thr_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH:    width_reg   <= cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg  <= cfg_wdata[HEIGHT_W-1:0];
                REG_KERNEL_LEFT:    kern_reg[0] <= cfg_wdata[KREG_W-1:0];
                REG_KERNEL_MID:     kern_reg[1] <= cfg_wdata[KREG_W-1:0];
                REG_KERNEL_RIGHT:   kern_reg[2] <= cfg_wdata[KREG_W-1:0];
                REG_MASK_ENABLE:    men_reg     <= cfg_wdata[0];
                REG_MASK_THRESHOLD: thr_reg     <= cfg_wdata[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // Effective frame size, clamped to the supported range.
    logic [WEW-1:0] w_eff;
    logic [HEW-1:0] h_eff;

    always_comb
    begin
        if (width_reg < WIDTH_W'(MIN_DIM))
            w_eff = WEW'(MIN_DIM);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = WEW'(MAX_WIDTH);
        else
            w_eff = WEW'(width_reg);
        if (height_reg < HEIGHT_W'(MIN_DIM))
            h_eff = HEW'(MIN_DIM);
        else if (32'(height_reg) > MAX_HEIGHT)
            h_eff = HEW'(MAX_HEIGHT);
        else
            h_eff = HEW'(height_reg);
    end

    // Pipeline control: everything moves when the tail can hand over.
    logic  adv;
    logic  accept;
    logic  conv_valid;
    rgb_t  conv_rgb;
    meta_t conv_meta;
    logic  can_load;

    assign adv          = !conv_valid || can_load;
    assign pixel.ready  = adv;
    assign accept       = pixel.valid && adv;

    // Raster position of the arriving pixel, after any fix-up for a changed size.
    logic [AW-1:0] col_count_reg, col_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic [AW-1:0] c0, c;
    logic [RW-1:0] r0, r;
    logic          interior, border;

    always_comb
    begin
        if (HEW'(row_count_reg) >= h_eff)
        begin
            c0 = '0;
            r0 = '0;
        end
        else
        begin
            c0 = col_count_reg;
            r0 = row_count_reg;
        end
        if (WEW'(c0) >= w_eff)
        begin
            c = '0;
            r = (HEW'(r0) + HEW'(1) >= h_eff) ? '0 : r0 + RW'(1);
        end
        else
        begin
            c = c0;
            r = r0;
        end
        if (WEW'(c) + WEW'(1) >= w_eff)
        begin
            col_count_next = '0;
            row_count_next = (HEW'(r) + HEW'(1) >= h_eff) ? '0 : r + RW'(1);
        end
        else
        begin
            col_count_next = c + AW'(1);
            row_count_next = r;
        end
        interior = (c >= AW'(2)) && (r >= RW'(2));
        border   = (r == '0) || (HEW'(r) == h_eff - HEW'(1))
                || (c == '0) || (WEW'(c) == w_eff - WEW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // First stage: the accepted word waits here while the line buffer is read.
    logic              s1_valid_reg;
    rgb_t              s1_pix_reg;
    logic [MASK_W-1:0] s1_mask_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic              s1_int_reg;
    logic              s1_bor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= {pixel.in_blue, pixel.in_green, pixel.in_red};
            s1_mask_reg <= pixel.in_mask;
            s1_addr_reg <= c;
            s1_col_reg  <= COL_W'(c);
            s1_row_reg  <= ROW_W'(r);
            s1_int_reg  <= interior;
            s1_bor_reg  <= border;
        end
    end

    // Line buffer: read at acceptance, written back when the word moves on.
    logic [LB_W-1:0]   lb_rd;
    rgb_t              a1, a2;
    logic [MASK_W-1:0] m1;
    logic              s1_move;

    assign s1_move = adv && s1_valid_reg;
    assign a2 = lb_rd[RGB_W-1:0];
    assign a1 = lb_rd[2*RGB_W-1:RGB_W];
    assign m1 = lb_rd[LB_W-1:2*RGB_W];

    mc3_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_linebuf (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (c),
        .rd_data (lb_rd),
        .wr_en   (s1_move),
        .wr_addr (s1_addr_reg),
        .wr_data ({s1_mask_reg, s1_pix_reg, a1})
    );

    // Column window and the mask of the centre pixel.
    rgb_t              win_reg [6];
    logic [MASK_W-1:0] cmask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
            cmask_reg <= '0;
        end
        else if (s1_move)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= a2;
            win_reg[4] <= a1;
            win_reg[5] <= s1_pix_reg;
            cmask_reg  <= m1;
        end
    end

    // Taps of the 3x3 neighbourhood, column by column, rows top to bottom.
    rgb_t  taps [TAPS];
    meta_t s1_meta;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            taps[i] = win_reg[i];
        end
        taps[6] = a2;
        taps[7] = a1;
        taps[8] = s1_pix_reg;
        s1_meta.pix      = s1_pix_reg;
        s1_meta.pass     = win_reg[4];
        s1_meta.col      = s1_col_reg;
        s1_meta.row      = s1_row_reg;
        s1_meta.interior = s1_int_reg;
        s1_meta.border   = s1_bor_reg;
        s1_meta.masked   = men_reg && ({1'b0, cmask_reg} < thr_reg);
    end

    mc3_conv #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s1_valid_reg),
        .taps      (taps),
        .kern      (kern_reg),
        .in_meta   (s1_meta),
        .out_valid (conv_valid),
        .out_rgb   (conv_rgb),
        .out_meta  (conv_meta)
    );

    mc3_outbuf u_outbuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (conv_valid && can_load),
        .conv_rgb (conv_rgb),
        .meta     (conv_meta),
        .can_load (can_load),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mc3_checker.sv =====
// Port-level checks for the masked 3x3 convolution core, bound to the top level.
// Depends on mc3_pkg for the field widths.
`default_nettype none

module mc3_port_checks
    import mc3_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic out_last,
    input wire logic [3*CHAN_W+COL_W+ROW_W:0] out_word
);

    // A stalled word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word withdrawn while stalled");

    // A stalled word keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("result word changed while stalled");

    // The second word of a pixel is already buffered behind the first.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_last |=> out_valid && out_last)
        else $error("second word of a pixel missing");

    // Nothing is offered once reset has been seen at a clock edge.
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result offered during reset");

endmodule

bind masked_conv3x3_rgb16_core mc3_port_checks u_mc3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_last  (result.out_last),
    .out_word  ({result.out_red, result.out_green, result.out_blue,
                 result.out_col, result.out_row, result.out_last})
);

`default_nettype wire
